@@ design/pulse_rate_ratio_meter_assert.svh @@
// assertion macros used by the meter's divider module
`ifndef PULSE_RATE_RATIO_METER_ASSERT_SVH
`define PULSE_RATE_RATIO_METER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PRRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prrm check failed");

// next-cycle implication, checked outside reset
`define PRRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prrm check failed");

`endif

@@ design/prrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prrm_pkg;

   // field widths
   localparam int PULSE_W = 16;
   localparam int TICK_W  = 32;
   localparam int FREQ_W  = 16;

   // pulse difference clamp and numerator shift
   localparam int PULSE_CLAMP_W = 14;
   localparam int NUM_SHIFT     = 18;
   localparam logic [PULSE_CLAMP_W-1:0] PULSE_CLAMP = 14'h3FFF;

   // frequency reported for a zero tick interval
   localparam logic [FREQ_W-1:0] ZERO_INTERVAL_FREQ = 16'hFFFE;

   // divider iteration count, one quotient bit per cycle
   localparam int DIV_STEPS = TICK_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // quotient bits kept for the result
   localparam int QUO_W = FREQ_W;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // control from the top level to the divider
   typedef struct packed {
      logic start;
      logic take;
   } div_ctl_type;

   // status from the divider to the top level
   typedef struct packed {
      logic ready;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ design/prrm_delta.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prrm_delta
   import prrm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic [PULSE_W-1:0] pulse_count,
   input  wire logic [TICK_W-1:0]  tick_count,
   output logic      [TICK_W-1:0]  numerator,
   output logic      [TICK_W-1:0]  denominator,
   output logic                    zero_interval
);

   logic [PULSE_W-1:0]       last_pulse_ff, last_pulse_in;
   logic [TICK_W-1:0]        last_tick_ff, last_tick_in;
   logic [PULSE_W-1:0]       pulse_diff;
   logic [PULSE_CLAMP_W-1:0] pulse_clamped;

   // wraparound differences against the previous snapshots
   always_comb begin
      pulse_diff  = pulse_count - last_pulse_ff;
      denominator = tick_count - last_tick_ff;
      zero_interval = (denominator == '0);
   end

   // clamp the pulse difference and align it as the numerator
   always_comb begin
      if (pulse_diff[PULSE_W-1:PULSE_CLAMP_W] != '0) begin
         pulse_clamped = PULSE_CLAMP;
      end else begin
         pulse_clamped = pulse_diff[PULSE_CLAMP_W-1:0];
      end
      numerator = {pulse_clamped, {NUM_SHIFT{1'b0}}};
   end

   // snapshot update on each accepted item
   always_comb begin
      last_pulse_in = last_pulse_ff;
      last_tick_in  = last_tick_ff;
      if (load) begin
         last_pulse_in = pulse_count;
         last_tick_in  = tick_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pulse_ff <= '0;
         last_tick_ff  <= '0;
      end else begin
         last_pulse_ff <= last_pulse_in;
         last_tick_ff  <= last_tick_in;
      end
   end

endmodule

`default_nettype wire

@@ design/prrm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_rate_ratio_meter_assert.svh"

module prrm_div
   import prrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire div_ctl_type        ctl,
   input  wire logic [TICK_W-1:0]  numerator,
   input  wire logic [TICK_W-1:0]  denominator,
   output div_status_type          status,
   output logic      [QUO_W-1:0]   quotient,
   output logic                    quotient_big
);

   div_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TICK_W-1:0]      num_ff, num_in;
   logic [TICK_W-1:0]      den_ff, den_in;
   logic [TICK_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic                   sticky_ff, sticky_in;
   logic [TICK_W:0]        rem_shift;
   logic [TICK_W:0]        rem_trial;
   logic                   fits;
   logic                   step;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (ctl.take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      status.ready = 1'b0;
      status.done  = 1'b0;
      step         = 1'b0;
      case (state_ff)
         DIV_IDLE: status.ready = 1'b1;
         DIV_RUN:  step         = 1'b1;
         DIV_DONE: status.done  = 1'b1;
         default: begin
            status.ready = 1'b0;
         end
      endcase
   end

   // one restoring step: bring down the next numerator bit and trial subtract
   always_comb begin
      rem_shift = {rem_ff, num_ff[TICK_W-1]};
      rem_trial = rem_shift - {1'b0, den_ff};
      fits      = (rem_shift >= {1'b0, den_ff});
   end

   // datapath shift registers
   always_comb begin
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sticky_in = sticky_ff;
      if (ctl.start && status.ready) begin
         cnt_in    = DIV_CNT_W'(DIV_STEPS - 1);
         num_in    = numerator;
         den_in    = denominator;
         rem_in    = '0;
         quo_in    = '0;
         sticky_in = 1'b0;
      end else if (step) begin
         cnt_in    = cnt_ff - 1'b1;
         num_in    = {num_ff[TICK_W-2:0], 1'b0};
         rem_in    = fits ? rem_trial[TICK_W-1:0] : rem_shift[TICK_W-1:0];
         quo_in    = {quo_ff[QUO_W-2:0], fits};
         sticky_in = sticky_ff | quo_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      sticky_ff <= sticky_in;
   end

   // low quotient bits and a flag for anything at or above bit 15
   assign quotient     = quo_ff;
   assign quotient_big = sticky_ff | quo_ff[QUO_W-1];

   `PRRM_ASSERT_NEXT(a_start_loads, clock, reset, ctl.start && status.ready,
      state_ff == DIV_RUN && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1))
   `PRRM_ASSERT_NEXT(a_last_step_done, clock, reset, state_ff == DIV_RUN && cnt_ff == '0,
      state_ff == DIV_DONE)
   `PRRM_ASSERT_NEXT(a_take_frees, clock, reset, state_ff == DIV_DONE && ctl.take,
      state_ff == DIV_IDLE)
   `PRRM_ASSERT_NOW(a_remainder_below_divisor, clock, reset,
      state_ff == DIV_DONE && den_ff != '0, rem_ff < den_ff)

endmodule

`default_nettype wire

@@ design/pulse_rate_ratio_meter.sv @@
// pulse rate ratio meter
// req channel: one item carries snapshots of a free-running 16-bit pulse
// counter and a 32-bit tick counter. the block differences them against
// the previous item, clamps the pulse delta to 16383, scales it by 2^18
// and divides by the tick delta; tdata carries twice the quotient.
// rsp channel: one item per request, frequency in tdata, flags in tuser.
// rsp_tvalid rises once the output register takes the result: the accept
// edge loads the divider, the bit-serial restoring divider retires one
// quotient bit per cycle, and the result moves on once the register is free.
// a new request is taken only while the divider is idle, after its previous
// result has moved to the output register.
// a zero tick delta reports 65534 with zero_interval set.
// reset clears both snapshots to zero, empties the result register and
// returns the divider to idle.
// a stalled receiver holds the result in the output register; the next
// item may still be taken and divided, and waits in the divider until
// the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module pulse_rate_ratio_meter
   import prrm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // pulse_count[15:0], tick_count[47:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // frequency[15:0]
   output logic [1:0]       rsp_tuser    // ratio_overflow[0], zero_interval[1]
);

   logic                req_accept;
   logic [TICK_W-1:0]   numerator;
   logic [TICK_W-1:0]   denominator;
   logic                zero_now;
   div_ctl_type         div_ctl;
   div_status_type      div_status;
   logic [QUO_W-1:0]    quotient;
   logic                quotient_big;
   logic                zero_ff, zero_in;
   logic                out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0]   out_freq_ff, out_freq_in;
   logic                out_ovf_ff, out_ovf_in;
   logic                out_zero_ff, out_zero_in;
   logic                out_free;

   assign req_tready = div_status.ready;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign div_ctl.start = req_accept;
   assign div_ctl.take  = div_status.done && out_free;

   prrm_delta u_delta (
      .clock         (clock),
      .reset         (reset),
      .load          (req_accept),
      .pulse_count   (req_tdata[PULSE_W-1:0]),
      .tick_count    (req_tdata[PULSE_W+TICK_W-1:PULSE_W]),
      .numerator     (numerator),
      .denominator   (denominator),
      .zero_interval (zero_now)
   );

   prrm_div u_div (
      .clock        (clock),
      .reset        (reset),
      .ctl          (div_ctl),
      .numerator    (numerator),
      .denominator  (denominator),
      .status       (div_status),
      .quotient     (quotient),
      .quotient_big (quotient_big)
   );

   // zero interval flag travels beside the divider
   assign zero_in = req_accept ? zero_now : zero_ff;

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_freq_in  = out_freq_ff;
      out_ovf_in   = out_ovf_ff;
      out_zero_in  = out_zero_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (div_ctl.take) begin
         out_valid_in = 1'b1;
         out_zero_in  = zero_ff;
         if (zero_ff) begin
            out_freq_in = ZERO_INTERVAL_FREQ;
            out_ovf_in  = 1'b0;
         end else begin
            out_freq_in = {quotient[QUO_W-2:0], 1'b0};
            out_ovf_in  = quotient_big;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff     <= zero_in;
      out_freq_ff <= out_freq_in;
      out_ovf_ff  <= out_ovf_in;
      out_zero_ff <= out_zero_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_freq_ff;
   assign rsp_tuser  = {out_zero_ff, out_ovf_ff};

endmodule

`default_nettype wire

@@ sim/pulse_rate_ratio_meter_test.sv @@
`timescale 1ns / 1ps

module pulse_rate_ratio_meter_test
   import prrm_pkg::*;
();

   // receiver hold-off used to back the block up
   localparam int LONG_HOLD_CYCLES = 300;
   // settle time after the last result
   localparam int DRAIN_CYCLES = 80;

   // one measurement as the block reports it
   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic              ratio_overflow;
      logic              zero_interval;
   } meter_reading_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata = '0;    // pulse_count[15:0], tick_count[47:16]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;         // frequency[15:0]
   logic [1:0]        rsp_tuser;         // ratio_overflow[0], zero_interval[1]

   // snapshots of the previous accepted item
   logic [PULSE_W-1:0] last_pulse_seen = '0;
   logic [TICK_W-1:0]  last_tick_seen = '0;

   meter_reading_type expected_readings[$];
   int                 mismatch_count = 0;
   bit                 idle_enable = 1'b1;
   int                 hold_requests = 0;

   pulse_rate_ratio_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // expected reading from the new snapshots and the previous ones
   function automatic meter_reading_type predict_reading(
      input logic [PULSE_W-1:0] pulses,
      input logic [TICK_W-1:0]  ticks,
      input logic [PULSE_W-1:0] prev_pulses,
      input logic [TICK_W-1:0]  prev_ticks
   );
      logic [PULSE_W-1:0]       pulse_delta;
      logic [PULSE_CLAMP_W-1:0] pulse_clamped;
      logic [TICK_W-1:0]        numerator;
      logic [TICK_W-1:0]        tick_delta;
      logic [TICK_W-1:0]        quotient;
      meter_reading_type        reading;
      pulse_delta = pulses - prev_pulses;
      pulse_clamped = (pulse_delta > PULSE_CLAMP) ? PULSE_CLAMP : pulse_delta[PULSE_CLAMP_W-1:0];
      numerator = TICK_W'(pulse_clamped) << NUM_SHIFT;
      tick_delta = ticks - prev_ticks;
      if (tick_delta == '0) begin
         reading.frequency = ZERO_INTERVAL_FREQ;
         reading.ratio_overflow = 1'b0;
         reading.zero_interval = 1'b1;
      end else begin
         quotient = numerator / tick_delta;
         reading.frequency = {quotient[QUO_W-2:0], 1'b0};
         reading.ratio_overflow = (quotient > 32'd32767);
         reading.zero_interval = 1'b0;
      end
      return reading;
   endfunction

   // offer one snapshot item and record its expected reading on accept
   task automatic send_snapshot(input logic [PULSE_W-1:0] pulses,
                                input logic [TICK_W-1:0] ticks);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ticks, pulses};
      do @(posedge clock); while (!req_tready);
      expected_readings.push_back(
         predict_reading(pulses, ticks, last_pulse_seen, last_tick_seen));
      last_pulse_seen = pulses;
      last_tick_seen = ticks;
   endtask

   // one random item: mostly counters moving forward, some noise
   task automatic send_random_snapshot();
      logic [PULSE_W-1:0] pulse_step;
      logic [TICK_W-1:0]  tick_step;
      int                 mode;
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0: pulse_step = PULSE_W'($urandom_range(0, 64));
         1: pulse_step = PULSE_W'($urandom_range(0, 16383));
         2: pulse_step = PULSE_W'($urandom_range(16384, 65535));
         default: pulse_step = PULSE_W'($urandom_range(0, 2000));
      endcase
      tick_step = $urandom & (32'hFFFF_FFFF >> $urandom_range(0, 31));
      if (mode == 0) begin
         send_snapshot(PULSE_W'($urandom), $urandom);
      end else if (mode == 1) begin
         send_snapshot(last_pulse_seen + pulse_step, last_tick_seen);
      end else begin
         send_snapshot(last_pulse_seen + pulse_step, last_tick_seen + tick_step);
      end
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin : receiver
      static int hold_served = 0;
      static int hold_left = 0;
      static int stall_left = 0;
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each accepted result with the oldest expected reading
   always @(posedge clock) begin : result_check
      meter_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result: frequency %0d, tuser %b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tdata !== want.frequency) begin
               $error("frequency mismatch: expected %0d, actual %0d",
                      want.frequency, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.ratio_overflow) begin
               $error("ratio_overflow mismatch: expected %0d, actual %0d",
                      want.ratio_overflow, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.zero_interval) begin
               $error("zero_interval mismatch: expected %0d, actual %0d",
                      want.zero_interval, rsp_tuser[1]);
               mismatch_count++;
            end
         end
      end
   end

   // differences taken against the cleared snapshots
   task automatic test_first_after_reset();
      send_snapshot(16'd100, 32'd1000);
   endtask

   // same tick value twice, with and without pulses in between
   task automatic test_zero_interval();
      send_snapshot(16'd200, 32'd1000);
      send_snapshot(16'd200, 32'd1000);
   endtask

   // quotient just above and below the 15-bit limit, then far above it
   task automatic test_ratio_overflow();
      send_snapshot(16'd201, 32'd1008);
      send_snapshot(16'd202, 32'd1017);
      send_snapshot(16'd16585, 32'd1018);
   endtask

   // pulse deltas above, at and one over the clamp
   task automatic test_pulse_clamp();
      send_snapshot(16'd36585, 32'd101018);
      send_snapshot(16'd52968, 32'd106018);
      send_snapshot(16'd3816, 32'd111018);
   endtask

   // both counters wrapping between two items
   task automatic test_counter_wrap();
      send_snapshot(16'hFFF0, 32'hFFFF_FF00);
      send_snapshot(16'h0010, 32'h0000_0100);
   endtask

   // all-ones and all-zeros snapshots in several combinations
   task automatic test_field_extremes();
      send_snapshot(16'hFFFF, 32'hFFFF_FFFF);
      send_snapshot(16'h0000, 32'h0000_0000);
      send_snapshot(16'hFFFF, 32'h0000_0000);
      send_snapshot(16'h0000, 32'hFFFF_FFFF);
      send_snapshot(16'hFFFF, 32'hFFFF_FFFE);
      send_snapshot(16'hFFFF, 32'hFFFF_FFFF);
   endtask

   // random items with idling on both sides
   task automatic test_random_mixed(input int count);
      repeat (count) send_random_snapshot();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure(input int count);
      hold_requests++;
      repeat (count) send_random_snapshot();
   endtask

   // back-to-back stream with no idling on either side
   task automatic test_steady_stream(input int count);
      idle_enable = 1'b0;
      repeat (count) send_random_snapshot();
   endtask

   // stimulus sequence and end of run
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_first_after_reset();
      test_zero_interval();
      test_ratio_overflow();
      test_pulse_clamp();
      test_counter_wrap();
      test_field_extremes();
      test_random_mixed(900);
      test_backpressure(30);
      test_random_mixed(20);
      test_steady_stream(400);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard
   initial begin
      #6_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/prrm_pkg.sv
design/prrm_delta.sv
design/prrm_div.sv
design/pulse_rate_ratio_meter.sv
sim/pulse_rate_ratio_meter_test.sv
